>>> rtl/core/ntt_pkg.sv
// Package for the number theoretic transform unit.
// Holds the widths, register indexes, command encodings and state codes.
// No dependencies; every other file of the block imports it.
package ntt_pkg;

  localparam int unsigned DATA_W     = 30;
  localparam int unsigned LOG_W      = 3;
  localparam int unsigned MAX_LOG    = 6;
  localparam int unsigned MAX_POINTS = 64;
  localparam int unsigned ADDR_W     = 6;
  localparam int unsigned CNT_W      = 7;
  localparam int unsigned BIT_W      = 5;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [LOG_W-1:0]  RESET_LOG_SIZE  = 3'd6;
  localparam logic [DATA_W-1:0] RESET_MODULUS   = 30'd998244353;
  localparam logic [DATA_W-1:0] RESET_GENERATOR = 30'd3;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOG_SIZE  = 2'd0,
    CFG_INVERSE   = 2'd1,
    CFG_MODULUS   = 2'd2,
    CFG_GENERATOR = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [LOG_W-1:0]  log_size;
    logic              inverse_mode;
    logic [DATA_W-1:0] modulus;
    logic [DATA_W-1:0] generator;
  } cfg_t;

  // Multiplier operand sources.
  typedef enum logic [2:0] {
    MX_IN, MX_RD, MX_GEN, MX_ACC, MX_TW, MX_NPTS
  } mul_x_e;

  typedef enum logic [2:0] {
    MY_ONE, MY_ACC, MY_BASE, MY_W, MY_SC, MY_TW
  } mul_y_e;

  // Register loaded from the multiplier result.
  typedef enum logic [2:0] {
    MD_NONE, MD_ACC, MD_BASE, MD_TW, MD_B
  } mul_dst_e;

  // Register loaded from the power accumulator.
  typedef enum logic [1:0] {
    CP_NONE, CP_BASE, CP_W, CP_SC
  } copy_e;

  typedef enum logic [2:0] {
    WS_MUL, WS_A, WS_B, WS_SUM, WS_DIFF
  } wr_sel_e;

  typedef enum logic [1:0] {
    OS_RD, OS_MUL, OS_ZERO
  } out_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              in_ld;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    wr_sel_e           wr_sel;
    logic              a_ld;
    logic              b_ld;
    logic              mul_start;
    mul_x_e            mul_x;
    mul_y_e            mul_y;
    mul_dst_e          mul_dst;
    copy_e             copy;
    logic              acc_one;
    logic              tw_one;
    logic              clr_valid;
    logic              out_ld;
    out_sel_e          out_sel;
    logic              out_last;
    logic [CNT_W-1:0]  npts;
  } dp_cmd_t;

  typedef enum logic [5:0] {
    S_IDLE, S_LD_WAIT,
    S_PR_RD, S_PR_MUL, S_PR_WAIT,
    S_BR_CHK, S_BR_RDA, S_BR_RDB, S_BR_LB, S_BR_WA, S_BR_WB, S_BR_NX,
    S_ST_INIT, S_ST_GEN_W, S_ST_INV, S_ST_W,
    S_PW_SQ, S_PW_SQW, S_PW_ML, S_PW_MLW, S_PW_NX,
    S_BF_RDA, S_BF_RDB, S_BF_MUL, S_BF_WAIT, S_BF_WA, S_BF_WB, S_TW_WAIT,
    S_SC_INIT, S_SC_WAIT, S_SC_SET,
    S_OUT_RD, S_OUT_LD, S_OUT_WAIT, S_OUT_HOLD
  } ctl_state_e;

  // Reverses the low lg bits of an index.
  function automatic logic [ADDR_W-1:0] bit_rev(input logic [ADDR_W-1:0] idx,
                                                input logic [LOG_W-1:0]  lg);
    logic [ADDR_W-1:0] r;
    for (int b = 0; b < ADDR_W; b++) begin
      r[ADDR_W-1-b] = idx[b];
    end
    return r >> (LOG_W'(ADDR_W) - lg);
  endfunction

endpackage

>>> rtl/core/ntt_stream_if.sv
// Valid/ready channel interfaces for the transform unit's input and output beats.
// Depends on ntt_pkg for the residue width.
interface ntt_in_if;
  import ntt_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] coefficient;
  logic              last_in;

  modport source (output valid, coefficient, last_in, input ready);
  modport sink   (input valid, coefficient, last_in, output ready);
endinterface

interface ntt_out_if;
  import ntt_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] value;
  logic              last_out;

  modport source (output valid, value, last_out, input ready);
  modport sink   (input valid, value, last_out, output ready);
endinterface

>>> rtl/core/number_theoretic_transform_unit.sv
// Radix-2 number theoretic transform of 2^log_size points (2 to 64) over a
// configurable prime modulus. Each input beat is reduced by the bit-serial
// modular multiplier; the beat that is marked last, or that fills the size,
// starts the run. A run uses the one multiplier for everything: the reduction
// of each entry, the butterflies (n/2 log n of them), the twiddle steps, and
// for each stage two 30-bit exponentiations (one if forward), each a square
// per exponent bit plus a multiply per set bit.
// The inverse scaling adds one more exponentiation and a multiply per result.
// Results leave one beat at a time in natural order, the last one marked.
// Depends on ntt_pkg, the channel interfaces, ntt_controller and ntt_datapath.
module number_theoretic_transform_unit
  import ntt_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DATA_W-1:0]    cfg_wdata_i,
  ntt_in_if.sink               in_i,
  ntt_out_if.source            out_o
);

  cfg_t    cfg_q;
  dp_cmd_t cmd;
  logic    mul_done;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.log_size     <= RESET_LOG_SIZE;
      cfg_q.inverse_mode <= 1'b0;
      cfg_q.modulus      <= RESET_MODULUS;
      cfg_q.generator    <= RESET_GENERATOR;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_LOG_SIZE:  cfg_q.log_size     <= cfg_wdata_i[LOG_W-1:0];
        CFG_INVERSE:   cfg_q.inverse_mode <= cfg_wdata_i[0];
        CFG_MODULUS:   cfg_q.modulus      <= cfg_wdata_i;
        CFG_GENERATOR: cfg_q.generator    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  ntt_controller u_ctl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_i.valid),
    .in_last_i   (in_i.last_in),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .mul_done_i  (mul_done),
    .cmd_o       (cmd)
  );

  ntt_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (cmd),
    .in_coeff_i  (in_i.coefficient),
    .mul_done_o  (mul_done),
    .out_value_o (out_o.value),
    .out_last_o  (out_o.last_out)
  );

endmodule

>>> rtl/core/ntt_modmul.sv
// Bit-serial modular multiplier: one bit of x per cycle, most significant bit first.
// Requires y below the modulus; x may be any value. Depends on ntt_pkg.
module ntt_modmul
  import ntt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DATA_W-1:0] x_i,
  input  logic [DATA_W-1:0] y_i,
  input  logic [DATA_W-1:0] m_i,
  output logic              done_o,
  output logic [DATA_W-1:0] res_o
);

  logic              busy_q;
  logic              done_q;
  logic [BIT_W-1:0]  cnt_q;
  logic [DATA_W-1:0] xs_q;
  logic [DATA_W-1:0] y_q;
  logic [DATA_W-1:0] m_q;
  logic [DATA_W-1:0] r_q;
  logic [DATA_W+1:0] t;
  logic [DATA_W+1:0] t1;
  logic [DATA_W+1:0] t2;
  logic [DATA_W-1:0] r_d;

  // One step: r = (2r + x_bit * y) mod m, with the sum kept below 3m.
  always_comb begin
    t  = {1'b0, r_q, 1'b0} + (xs_q[DATA_W-1] ? {2'b00, y_q} : '0);
    t1 = t - {2'b00, m_q};
    t2 = t - {1'b0, m_q, 1'b0};
    if (t >= {1'b0, m_q, 1'b0}) begin
      r_d = t2[DATA_W-1:0];
    end else if (t >= {2'b00, m_q}) begin
      r_d = t1[DATA_W-1:0];
    end else begin
      r_d = t[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= BIT_W'(DATA_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - BIT_W'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operand and partial result registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      xs_q <= x_i;
      y_q  <= y_i;
      m_q  <= m_i;
      r_q  <= '0;
    end else if (busy_q) begin
      xs_q <= {xs_q[DATA_W-2:0], 1'b0};
      r_q  <= r_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = r_q;

endmodule

>>> rtl/core/ntt_datapath.sv
// Datapath of the transform unit: coefficient memory with valid bits, butterfly
// add/subtract, power and twiddle registers, multiplier and output register.
// Depends on ntt_pkg and ntt_modmul.
module ntt_datapath
  import ntt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  dp_cmd_t           cmd_i,
  input  logic [DATA_W-1:0] in_coeff_i,
  output logic              mul_done_o,
  output logic [DATA_W-1:0] out_value_o,
  output logic              out_last_o
);

  logic [DATA_W-1:0]     mem_q [MAX_POINTS];
  logic [MAX_POINTS-1:0] valid_q;
  logic [DATA_W-1:0]     rdata_q;
  logic                  rvalid_q;
  logic [DATA_W-1:0]     rd_val;

  logic [DATA_W-1:0] in_q;
  logic [DATA_W-1:0] a_q;
  logic [DATA_W-1:0] b_q;
  logic [DATA_W-1:0] acc_q;
  logic [DATA_W-1:0] base_q;
  logic [DATA_W-1:0] w_q;
  logic [DATA_W-1:0] tw_q;
  logic [DATA_W-1:0] sc_q;
  logic [DATA_W-1:0] out_q;
  logic              last_q;

  logic [DATA_W-1:0] mul_x;
  logic [DATA_W-1:0] mul_y;
  logic [DATA_W-1:0] mul_res;
  logic [DATA_W:0]   sum;
  logic [DATA_W:0]   sum_red;
  logic [DATA_W:0]   diff;
  logic [DATA_W-1:0] wdata;

  // Entries never written since the last clear read as zero.
  assign rd_val = rvalid_q ? rdata_q : '0;

  // Multiplier operand selection.
  always_comb begin
    unique case (cmd_i.mul_x)
      MX_IN:   mul_x = in_q;
      MX_RD:   mul_x = rd_val;
      MX_GEN:  mul_x = cfg_i.generator;
      MX_ACC:  mul_x = acc_q;
      MX_TW:   mul_x = tw_q;
      MX_NPTS: mul_x = DATA_W'(cmd_i.npts);
      default: mul_x = '0;
    endcase
    unique case (cmd_i.mul_y)
      MY_ONE:  mul_y = DATA_W'(1);
      MY_ACC:  mul_y = acc_q;
      MY_BASE: mul_y = base_q;
      MY_W:    mul_y = w_q;
      MY_SC:   mul_y = sc_q;
      MY_TW:   mul_y = tw_q;
      default: mul_y = '0;
    endcase
  end

  ntt_modmul u_modmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .x_i     (mul_x),
    .y_i     (mul_y),
    .m_i     (cfg_i.modulus),
    .done_o  (mul_done_o),
    .res_o   (mul_res)
  );

  // Butterfly: a + b and a - b modulo the modulus.
  always_comb begin
    sum     = {1'b0, a_q} + {1'b0, b_q};
    sum_red = (sum >= {1'b0, cfg_i.modulus}) ? sum - {1'b0, cfg_i.modulus} : sum;
    diff    = {1'b0, a_q} - {1'b0, b_q} + ((a_q < b_q) ? {1'b0, cfg_i.modulus} : '0);
    unique case (cmd_i.wr_sel)
      WS_MUL:  wdata = mul_res;
      WS_A:    wdata = a_q;
      WS_B:    wdata = b_q;
      WS_SUM:  wdata = sum_red[DATA_W-1:0];
      WS_DIFF: wdata = diff[DATA_W-1:0];
      default: wdata = '0;
    endcase
  end

  // Coefficient memory, registered read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[cmd_i.wr_addr] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[cmd_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (cmd_i.rd_en) begin
        rvalid_q <= valid_q[cmd_i.rd_addr];
      end
      if (cmd_i.clr_valid) begin
        valid_q <= '0;
      end else if (cmd_i.wr_en) begin
        valid_q[cmd_i.wr_addr] <= 1'b1;
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.in_ld) in_q <= in_coeff_i;
    if (cmd_i.a_ld) a_q <= rd_val;
    if (cmd_i.b_ld) begin
      b_q <= rd_val;
    end else if (mul_done_o && cmd_i.mul_dst == MD_B) begin
      b_q <= mul_res;
    end
    if (cmd_i.acc_one) begin
      acc_q <= DATA_W'(1);
    end else if (mul_done_o && cmd_i.mul_dst == MD_ACC) begin
      acc_q <= mul_res;
    end
    if (cmd_i.copy == CP_BASE) begin
      base_q <= acc_q;
    end else if (mul_done_o && cmd_i.mul_dst == MD_BASE) begin
      base_q <= mul_res;
    end
    if (cmd_i.copy == CP_W) w_q <= acc_q;
    if (cmd_i.copy == CP_SC) sc_q <= acc_q;
    if (cmd_i.tw_one) begin
      tw_q <= DATA_W'(1);
    end else if (mul_done_o && cmd_i.mul_dst == MD_TW) begin
      tw_q <= mul_res;
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      unique case (cmd_i.out_sel)
        OS_RD:   out_q <= rd_val;
        OS_MUL:  out_q <= mul_res;
        OS_ZERO: out_q <= '0;
        default: out_q <= '0;
      endcase
      last_q <= cmd_i.out_last;
    end
  end

  assign out_value_o = out_q;
  assign out_last_o  = last_q;

endmodule

>>> rtl/core/ntt_controller.sv
// Controller of the transform unit: load, reduce, bit-reverse, butterfly stages,
// twiddle powers, inverse scaling and readout, as one state machine.
// Depends on ntt_pkg.
module ntt_controller
  import ntt_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    in_valid_i,
  input  logic    in_last_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  logic    mul_done_i,
  output dp_cmd_t cmd_o
);

  ctl_state_e        state_q, state_d;
  ctl_state_e        ret_q, ret_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  j_q, j_d;
  logic [LOG_W-1:0]  stg_q, stg_d;
  logic [DATA_W-1:0] e_q, e_d;
  logic [BIT_W-1:0]  ebit_q, ebit_d;
  logic              last_q, last_d;
  logic              zero_q, zero_d;

  logic [LOG_W-1:0]  lg;
  logic [CNT_W-1:0]  npts;
  logic [CNT_W-1:0]  last_idx;
  logic [CNT_W-1:0]  half;
  logic [CNT_W-1:0]  len;
  logic [CNT_W-1:0]  addr_a;
  logic [CNT_W-1:0]  addr_b;
  logic [CNT_W-1:0]  j_next;
  logic [CNT_W-1:0]  cnt_inc;
  logic [ADDR_W-1:0] rev;
  logic              small_mod;
  logic              accept;

  // Effective size: a log size of zero acts as one, above the maximum as the maximum.
  always_comb begin
    if (cfg_i.log_size == '0) begin
      lg = LOG_W'(1);
    end else if (cfg_i.log_size > LOG_W'(MAX_LOG)) begin
      lg = LOG_W'(MAX_LOG);
    end else begin
      lg = cfg_i.log_size;
    end
  end

  assign npts      = CNT_W'(1) << lg;
  assign last_idx  = npts - CNT_W'(1);
  assign half      = CNT_W'(1) << (stg_q - LOG_W'(1));
  assign len       = CNT_W'(1) << stg_q;
  assign addr_a    = j_q + idx_q;
  assign addr_b    = addr_a + half;
  assign j_next    = j_q + len;
  assign cnt_inc   = cnt_q + CNT_W'(1);
  assign rev       = bit_rev(idx_q[ADDR_W-1:0], lg);
  assign small_mod = cfg_i.modulus < DATA_W'(2);
  assign accept    = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    j_d     = j_q;
    stg_d   = stg_q;
    e_d     = e_q;
    ebit_d  = ebit_q;
    last_d  = last_q;
    zero_d  = zero_q;
    cmd_o   = '0;
    cmd_o.npts = npts;
    cmd_o.out_last = (idx_q == last_idx);
    in_ready_o  = (state_q == S_IDLE);
    out_valid_o = (state_q == S_OUT_HOLD);

    unique case (state_q)
      // Load one beat; a full store or a last mark starts the run.
      S_IDLE: begin
        if (accept) begin
          cmd_o.in_ld = 1'b1;
          idx_d = '0;
          if (cnt_q >= npts) begin
            zero_d  = small_mod;
            state_d = small_mod ? S_OUT_RD : S_PR_RD;
          end else if (small_mod) begin
            cnt_d = cnt_inc;
            if (in_last_i || cnt_inc >= npts) begin
              zero_d  = 1'b1;
              state_d = S_OUT_RD;
            end
          end else begin
            last_d  = in_last_i;
            state_d = S_LD_WAIT;
          end
        end
      end
      S_LD_WAIT: begin
        cmd_o.mul_x = MX_IN;
        cmd_o.mul_y = MY_ONE;
        if (!mul_done_i && ret_q != S_LD_WAIT) begin
          cmd_o.mul_start = 1'b1;
          ret_d = S_LD_WAIT;
        end else if (mul_done_i) begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_addr = cnt_q[ADDR_W-1:0];
          cmd_o.wr_sel  = WS_MUL;
          cnt_d = cnt_inc;
          ret_d = S_IDLE;
          if (last_q || cnt_inc >= npts) begin
            zero_d  = 1'b0;
            state_d = S_PR_RD;
          end else begin
            state_d = S_IDLE;
          end
        end
      end

      // Reduce every entry by the current modulus.
      S_PR_RD: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = idx_q[ADDR_W-1:0];
        state_d = S_PR_MUL;
      end
      S_PR_MUL: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_x = MX_RD;
        cmd_o.mul_y = MY_ONE;
        state_d = S_PR_WAIT;
      end
      S_PR_WAIT: begin
        if (mul_done_i) begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_addr = idx_q[ADDR_W-1:0];
          cmd_o.wr_sel  = WS_MUL;
          if (idx_q == last_idx) begin
            idx_d   = '0;
            state_d = S_BR_CHK;
          end else begin
            idx_d   = idx_q + CNT_W'(1);
            state_d = S_PR_RD;
          end
        end
      end

      // Bit-reversal permutation: swap each pair once.
      S_BR_CHK: begin
        state_d = (idx_q[ADDR_W-1:0] < rev) ? S_BR_RDA : S_BR_NX;
      end
      S_BR_RDA: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = idx_q[ADDR_W-1:0];
        state_d = S_BR_RDB;
      end
      S_BR_RDB: begin
        cmd_o.a_ld    = 1'b1;
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = rev;
        state_d = S_BR_LB;
      end
      S_BR_LB: begin
        cmd_o.b_ld = 1'b1;
        state_d = S_BR_WA;
      end
      S_BR_WA: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = idx_q[ADDR_W-1:0];
        cmd_o.wr_sel  = WS_B;
        state_d = S_BR_WB;
      end
      S_BR_WB: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = rev;
        cmd_o.wr_sel  = WS_A;
        state_d = S_BR_NX;
      end
      S_BR_NX: begin
        if (idx_q == last_idx) begin
          stg_d   = LOG_W'(1);
          state_d = S_ST_INIT;
        end else begin
          idx_d   = idx_q + CNT_W'(1);
          state_d = S_BR_CHK;
        end
      end

      // Stage twiddle step: generator^((m-1)/len), inverted for the inverse transform.
      S_ST_INIT: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_x = MX_GEN;
        cmd_o.mul_y = MY_ONE;
        state_d = S_ST_GEN_W;
      end
      S_ST_GEN_W: begin
        if (mul_done_i) begin
          cmd_o.mul_dst = MD_BASE;
          cmd_o.acc_one = 1'b1;
          e_d     = (cfg_i.modulus - DATA_W'(1)) >> stg_q;
          ebit_d  = BIT_W'(DATA_W - 1);
          ret_d   = S_ST_INV;
          state_d = S_PW_SQ;
        end
      end
      S_ST_INV: begin
        if (cfg_i.inverse_mode) begin
          cmd_o.copy    = CP_BASE;
          cmd_o.acc_one = 1'b1;
          e_d     = cfg_i.modulus - DATA_W'(2);
          ebit_d  = BIT_W'(DATA_W - 1);
          ret_d   = S_ST_W;
          state_d = S_PW_SQ;
        end else begin
          state_d = S_ST_W;
        end
      end
      S_ST_W: begin
        cmd_o.copy   = CP_W;
        cmd_o.tw_one = 1'b1;
        idx_d   = '0;
        j_d     = '0;
        state_d = S_BF_RDA;
      end

      // Square-and-multiply power, exponent bits from the top.
      S_PW_SQ: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_x = MX_ACC;
        cmd_o.mul_y = MY_ACC;
        state_d = S_PW_SQW;
      end
      S_PW_SQW: begin
        if (mul_done_i) begin
          cmd_o.mul_dst = MD_ACC;
          state_d = S_PW_ML;
        end
      end
      S_PW_ML: begin
        if (e_q[DATA_W-1]) begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_x = MX_ACC;
          cmd_o.mul_y = MY_BASE;
          state_d = S_PW_MLW;
        end else begin
          state_d = S_PW_NX;
        end
      end
      S_PW_MLW: begin
        if (mul_done_i) begin
          cmd_o.mul_dst = MD_ACC;
          state_d = S_PW_NX;
        end
      end
      S_PW_NX: begin
        e_d = {e_q[DATA_W-2:0], 1'b0};
        if (ebit_q == '0) begin
          state_d = ret_q;
        end else begin
          ebit_d  = ebit_q - BIT_W'(1);
          state_d = S_PW_SQ;
        end
      end

      // Butterflies, twiddle index outer, block offset inner.
      S_BF_RDA: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = addr_a[ADDR_W-1:0];
        state_d = S_BF_RDB;
      end
      S_BF_RDB: begin
        cmd_o.a_ld    = 1'b1;
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = addr_b[ADDR_W-1:0];
        state_d = S_BF_MUL;
      end
      S_BF_MUL: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_x = MX_RD;
        cmd_o.mul_y = MY_TW;
        state_d = S_BF_WAIT;
      end
      S_BF_WAIT: begin
        if (mul_done_i) begin
          cmd_o.mul_dst = MD_B;
          state_d = S_BF_WA;
        end
      end
      S_BF_WA: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = addr_a[ADDR_W-1:0];
        cmd_o.wr_sel  = WS_SUM;
        state_d = S_BF_WB;
      end
      S_BF_WB: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = addr_b[ADDR_W-1:0];
        cmd_o.wr_sel  = WS_DIFF;
        if (j_next < npts) begin
          j_d     = j_next;
          state_d = S_BF_RDA;
        end else if (idx_q + CNT_W'(1) == half) begin
          idx_d = '0;
          if (stg_q == lg) begin
            state_d = cfg_i.inverse_mode ? S_SC_INIT : S_OUT_RD;
          end else begin
            stg_d   = stg_q + LOG_W'(1);
            state_d = S_ST_INIT;
          end
        end else begin
          j_d     = '0;
          idx_d   = idx_q + CNT_W'(1);
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_x = MX_TW;
          cmd_o.mul_y = MY_W;
          state_d = S_TW_WAIT;
        end
      end
      S_TW_WAIT: begin
        if (mul_done_i) begin
          cmd_o.mul_dst = MD_TW;
          state_d = S_BF_RDA;
        end
      end

      // Inverse scale factor n^(m-2).
      S_SC_INIT: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_x = MX_NPTS;
        cmd_o.mul_y = MY_ONE;
        state_d = S_SC_WAIT;
      end
      S_SC_WAIT: begin
        if (mul_done_i) begin
          cmd_o.mul_dst = MD_BASE;
          cmd_o.acc_one = 1'b1;
          e_d     = cfg_i.modulus - DATA_W'(2);
          ebit_d  = BIT_W'(DATA_W - 1);
          ret_d   = S_SC_SET;
          state_d = S_PW_SQ;
        end
      end
      S_SC_SET: begin
        cmd_o.copy = CP_SC;
        idx_d   = '0;
        state_d = S_OUT_RD;
      end

      // Readout in natural order, one beat at a time.
      S_OUT_RD: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = idx_q[ADDR_W-1:0];
        state_d = S_OUT_LD;
      end
      S_OUT_LD: begin
        if (zero_q) begin
          cmd_o.out_ld  = 1'b1;
          cmd_o.out_sel = OS_ZERO;
          state_d = S_OUT_HOLD;
        end else if (cfg_i.inverse_mode) begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_x = MX_RD;
          cmd_o.mul_y = MY_SC;
          state_d = S_OUT_WAIT;
        end else begin
          cmd_o.out_ld  = 1'b1;
          cmd_o.out_sel = OS_RD;
          state_d = S_OUT_HOLD;
        end
      end
      S_OUT_WAIT: begin
        if (mul_done_i) begin
          cmd_o.out_ld  = 1'b1;
          cmd_o.out_sel = OS_MUL;
          state_d = S_OUT_HOLD;
        end
      end
      S_OUT_HOLD: begin
        if (out_ready_i) begin
          if (idx_q == last_idx) begin
            cmd_o.clr_valid = 1'b1;
            cnt_d   = '0;
            idx_d   = '0;
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + CNT_W'(1);
            state_d = S_OUT_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
      cnt_q   <= '0;
      idx_q   <= '0;
      j_q     <= '0;
      stg_q   <= LOG_W'(1);
      e_q     <= '0;
      ebit_q  <= '0;
      last_q  <= 1'b0;
      zero_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      j_q     <= j_d;
      stg_q   <= stg_d;
      e_q     <= e_d;
      ebit_q  <= ebit_d;
      last_q  <= last_d;
      zero_q  <= zero_d;
    end
  end

endmodule

>>> verif/ntt_scoreboard.sv
// Scoreboard for the transform unit: a software model of the transform and a
// queue of expected output beats. Depends on ntt_pkg for the register indexes.
`timescale 1ns / 1ps
class ntt_scoreboard;
  logic [29:0] sz_log;
  logic        inv;
  logic [29:0] prime;
  logic [29:0] root;
  longint unsigned coeffs[64];
  longint unsigned tw[64];
  int unsigned loaded;
  logic [29:0] exp_value[$];
  logic        exp_last[$];
  int unsigned errors;
  int unsigned checked;
  int unsigned runs;

  function new();
    sz_log = 6;
    inv = 0;
    prime = 998244353;
    root = 3;
    loaded = 0;
    errors = 0;
    checked = 0;
    runs = 0;
    foreach (coeffs[i]) coeffs[i] = 0;
  endfunction

  function void set_reg(ntt_pkg::cfg_idx_e idx, logic [29:0] data);
    case (idx)
      ntt_pkg::CFG_LOG_SIZE:  sz_log = data & 7;
      ntt_pkg::CFG_INVERSE:   inv = data[0];
      ntt_pkg::CFG_MODULUS:   prime = data;
      ntt_pkg::CFG_GENERATOR: root = data;
      default: ;
    endcase
  endfunction

  function longint unsigned power_mod(longint unsigned b, longint unsigned e,
                                      longint unsigned m);
    longint unsigned r;
    r = 1 % m;
    b = b % m;
    while (e != 0) begin
      if (e & 1) r = (r * b) % m;
      b = (b * b) % m;
      e = e >> 1;
    end
    return r;
  endfunction

  // Runs the whole transform on the stored vector and queues n output beats.
  function void transform(int unsigned lg, int unsigned n);
    longint unsigned m, w, a, b, t, sc;
    int unsigned r;
    m = prime;
    if (m < 2) begin
      for (int i = 0; i < n; i++) coeffs[i] = 0;
    end else begin
      for (int i = 0; i < n; i++) coeffs[i] = coeffs[i] % m;
      // Bit-reversal permutation.
      for (int i = 0; i < n; i++) begin
        r = 0;
        for (int k = 0; k < lg; k++) if ((i >> k) & 1) r |= 1 << (lg - 1 - k);
        if (i < r) begin
          t = coeffs[i];
          coeffs[i] = coeffs[r];
          coeffs[r] = t;
        end
      end
      // Butterfly stages.
      for (int len = 2; len <= n; len = len * 2) begin
        w = power_mod(root, (m - 1) / len, m);
        if (inv) w = power_mod(w, m - 2, m);
        tw[0] = 1 % m;
        for (int k = 1; k < len / 2; k++) tw[k] = (tw[k-1] * w) % m;
        for (int j = 0; j < n; j += len) begin
          for (int k = 0; k < len / 2; k++) begin
            a = coeffs[j+k];
            b = (coeffs[j+k+len/2] * tw[k]) % m;
            coeffs[j+k] = (a + b >= m) ? a + b - m : a + b;
            coeffs[j+k+len/2] = (a >= b) ? a - b : a + m - b;
          end
        end
      end
      if (inv) begin
        sc = power_mod(n, m - 2, m);
        for (int i = 0; i < n; i++) coeffs[i] = (coeffs[i] * sc) % m;
      end
    end
    for (int i = 0; i < n; i++) begin
      exp_value.push_back(coeffs[i][29:0]);
      exp_last.push_back(i == n - 1);
    end
    foreach (coeffs[i]) coeffs[i] = 0;
    loaded = 0;
    runs++;
  endfunction

  // Notes an accepted input beat.
  function void note_input(logic [29:0] coef, logic last);
    int unsigned lg, n;
    bit go;
    lg = sz_log;
    if (lg < 1) lg = 1;
    if (lg > 6) lg = 6;
    n = 1 << lg;
    go = last;
    if (loaded < n) begin
      coeffs[loaded % 64] = (prime < 2) ? 0 : coef % prime;
      loaded++;
      if (loaded >= n) go = 1;
    end else begin
      go = 1;
    end
    if (go) transform(lg, n);
  endfunction

  function void report(string what);
    $display("mismatch: %s", what);
    errors++;
  endfunction

  // Checks an accepted output beat against the oldest expectation.
  function void check_output(logic [29:0] value, logic last);
    logic [29:0] ev;
    logic el;
    if (exp_value.size() == 0) begin
      report($sformatf("unexpected beat value=%0d last=%0b", value, last));
      return;
    end
    ev = exp_value.pop_front();
    el = exp_last.pop_front();
    checked++;
    if (value !== ev) report($sformatf("value %0d, expected %0d", value, ev));
    if (last !== el) report($sformatf("last_out %0b, expected %0b", last, el));
  endfunction

  function int unsigned pending();
    return exp_value.size();
  endfunction
endclass

>>> verif/testbench.sv
// Top-level testbench of number_theoretic_transform_unit: random and directed
// vectors through the valid/ready channels, checked by ntt_scoreboard.
// Depends on ntt_pkg, the channel interfaces and ntt_scoreboard.
`timescale 1ns / 1ps
module testbench;
  import ntt_pkg::*;

  localparam longint unsigned CYCLE_LIMIT = 64'd40_000_000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [DATA_W-1:0]    cfg_wdata_i = '0;
  longint unsigned      cycles = 0;
  bit                   stall_enable = 1'b1;

  ntt_in_if  in_ch();
  ntt_out_if out_ch();
  ntt_scoreboard board = new();

  number_theoretic_transform_unit uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_i(in_ch.sink), .out_o(out_ch.source)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.coefficient = '0;
    in_ch.last_in = 1'b0;
    out_ch.ready = 1'b0;
  end

  // Random gap length: mostly short, sometimes long.
  function automatic int unsigned gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // Cycle limit and output-side sampling and stalls.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL number_theoretic_transform_unit");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      board.check_output(out_ch.value, out_ch.last_out);
    end
  end

  initial begin
    int unsigned g;
    @(posedge clk_i);
    forever begin
      g = stall_enable ? gap_len() : 0;
      if (g != 0) begin
        out_ch.ready <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  end

  // Registers are written only while the block is idle and owes no result.
  task automatic write_reg(cfg_idx_e idx, logic [DATA_W-1:0] data);
    @(posedge clk_i);
    while (board.pending() != 0 || !in_ch.ready) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    board.set_reg(idx, data);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Sends one input beat and waits for its acceptance; valid drops between beats.
  task automatic send_beat(logic [DATA_W-1:0] coef, logic last);
    int unsigned g;
    g = stall_enable ? gap_len() : 0;
    repeat (g + 1) @(posedge clk_i);
    in_ch.valid <= 1'b1;
    in_ch.coefficient <= coef;
    in_ch.last_in <= last;
    do @(posedge clk_i); while (!in_ch.ready);
    board.note_input(coef, last);
    in_ch.valid <= 1'b0;
  endtask

  // Waits until every expected beat has come, then lets the block settle.
  task automatic drain();
    while (board.pending() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  function automatic logic [DATA_W-1:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return DATA_W'($urandom);
    endcase
  endfunction

  // One vector of random length; mostly full or short with a last mark.
  task automatic send_vector(int unsigned n);
    int unsigned len;
    bit marked;
    marked = $urandom_range(0, 1);
    len = marked ? $urandom_range(1, n) : n + $urandom_range(0, 1);
    for (int i = 0; i < len; i++) begin
      send_beat(rand_coef(), marked && (i == len - 1));
    end
  endtask

  initial begin
    int unsigned n;
    int unsigned sent;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset settings, full 64-point vector with field extremes.
    for (int i = 0; i < 64; i++) begin
      send_beat((i % 2) ? '1 : DATA_W'(i), 1'b0);
    end
    drain();
    // Small forward and inverse runs, last_in alone and short vectors.
    write_reg(CFG_LOG_SIZE, DATA_W'(1));
    send_beat(30'd5, 1'b0);
    send_beat(30'd7, 1'b0);
    send_beat('1, 1'b1);
    write_reg(CFG_LOG_SIZE, DATA_W'(3));
    send_beat(30'd9, 1'b1);
    drain();
    write_reg(CFG_INVERSE, DATA_W'(1));
    send_beat(30'd1, 1'b0);
    send_beat(30'd2, 1'b1);
    drain();
    // Size out of range, modulus below two, size shrunk while loading.
    write_reg(CFG_LOG_SIZE, DATA_W'(0));
    send_beat(30'd3, 1'b1);
    drain();
    write_reg(CFG_LOG_SIZE, DATA_W'(7));
    write_reg(CFG_MODULUS, DATA_W'(1));
    send_beat(30'd11, 1'b1);
    drain();
    write_reg(CFG_MODULUS, DATA_W'(17));
    write_reg(CFG_GENERATOR, DATA_W'(3));
    write_reg(CFG_INVERSE, DATA_W'(0));
    write_reg(CFG_LOG_SIZE, DATA_W'(4));
    send_beat(30'd4, 1'b0);
    send_beat(30'd6, 1'b0);
    send_beat(30'd8, 1'b0);
    write_reg(CFG_LOG_SIZE, DATA_W'(1));
    send_beat(30'd10, 1'b0);
    drain();
    // Largest 30-bit prime, a generator above the modulus and a four-point size.
    write_reg(CFG_MODULUS, 30'd1073741789);
    write_reg(CFG_GENERATOR, 30'd1073741822);
    write_reg(CFG_LOG_SIZE, DATA_W'(2));
    send_beat('1, 1'b0);
    send_beat(30'd123456, 1'b1);
    drain();

    // Random phases over several settings; mostly small sizes.
    sent = 0;
    for (int phase = 0; sent < 200; phase++) begin
      case ($urandom_range(0, 3))
        0: begin
          write_reg(CFG_MODULUS, 30'd998244353);
          write_reg(CFG_GENERATOR, 30'd3);
        end
        1: begin
          write_reg(CFG_MODULUS, 30'd7681);
          write_reg(CFG_GENERATOR, 30'd17);
        end
        2: begin
          write_reg(CFG_MODULUS, 30'd257);
          write_reg(CFG_GENERATOR, 30'd3);
        end
        default: begin
          write_reg(CFG_MODULUS, DATA_W'($urandom));
          write_reg(CFG_GENERATOR, DATA_W'($urandom));
        end
      endcase
      write_reg(CFG_INVERSE, DATA_W'($urandom_range(0, 1)));
      write_reg(CFG_LOG_SIZE,
                DATA_W'(($urandom_range(0, 7) == 0) ? 6 : $urandom_range(0, 4)));
      n = 1 << ((board.sz_log < 1) ? 1 : (board.sz_log > 6) ? 6 : board.sz_log);
      stall_enable = (phase % 5) != 4;
      for (int v = 0; v < 3; v++) begin
        send_vector(n);
        sent += n;
      end
      drain();
    end

    $display("Covered %0d transform runs and %0d output beats over several sizes,",
             board.runs, board.checked);
    $display("both directions and several moduli, with stalls on both channels.");
    if (board.errors == 0 && board.pending() == 0) begin
      $display("PASS number_theoretic_transform_unit");
    end else begin
      $display("FAIL number_theoretic_transform_unit");
    end
    $finish;
  end
endmodule
